### rtl/core/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// shared types and codes of the lottery slot scheduler
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int OPC_W    = 2;
	localparam int TICKET_W = 16;
	localparam int THREAD_W = 8;
	localparam int RAND_W   = 32;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(RAND_W);

	// opcodes on the command channel
	localparam logic [OPC_W-1:0] OP_ADMIT  = 2'd0;
	localparam logic [OPC_W-1:0] OP_FINISH = 2'd1;
	localparam logic [OPC_W-1:0] OP_TICK   = 2'd2;

	// decoded command kinds
	localparam logic [1:0] KIND_ADMIT  = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_NOP    = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SLOT    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_TICKETS = 2'd2;

	// per-slot state
	localparam logic [1:0] SS_EMPTY    = 2'd0;
	localparam logic [1:0] SS_READY    = 2'd1;
	localparam logic [1:0] SS_RUNNING  = 2'd2;
	localparam logic [1:0] SS_FINISHED = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [TICKET_W-1:0] tickets;
		logic [THREAD_W-1:0] thread;
		logic [RAND_W-1:0]   rnd;
	} cmd_t;

endpackage

### rtl/core/lss_cmd_if.sv
// ----------------------------------------------------------------------------
// lss_cmd_if
// command channel: valid/ready with opcode, tickets, thread id and random word
// ----------------------------------------------------------------------------
interface lss_cmd_if import lss_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OPC_W-1:0]    opcode;
	logic [TICKET_W-1:0] ticket_count;
	logic [THREAD_W-1:0] thread_id;
	logic [RAND_W-1:0]   random_word;

	modport source (output valid, opcode, ticket_count, thread_id, random_word,
		input ready);
	modport sink (input valid, opcode, ticket_count, thread_id, random_word,
		output ready);
	modport mon (input valid, ready, opcode, ticket_count, thread_id, random_word);
endinterface

### rtl/core/lss_res_if.sv
// ----------------------------------------------------------------------------
// lss_res_if
// result channel: valid/ready with chosen slot, thread, switch flag and status
// ----------------------------------------------------------------------------
interface lss_res_if import lss_pkg::*; #(
	parameter int SLOT_W = 3
);
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   chosen_slot;
	logic [THREAD_W-1:0] chosen_thread;
	logic                switched;
	logic [STAT_W-1:0]   status;

	modport source (output valid, chosen_slot, chosen_thread, switched, status,
		input ready);
	modport sink (input valid, chosen_slot, chosen_thread, switched, status,
		output ready);
	modport mon (input valid, ready, chosen_slot, chosen_thread, switched, status);
endinterface

### rtl/core/lottery_slot_scheduler_unit.sv
// admit and opcode 3: the accepted beat goes through the command queue, then the
//   sequencer's idle, exec and response states into the result register
// draws: paced by the serial ticket sum, the 32-step bit-serial modulo and the
//   serial winner scan
// one item in the sequencer at a time; the queue takes two more beats meanwhile
// reset: all slots empty, tickets and ids zero, run register at slot 1 but not valid, nothing shown
// ----------------------------------------------------------------------------
// lottery_slot_scheduler_unit
// lottery scheduler over a small table of thread slots
// ----------------------------------------------------------------------------
module lottery_slot_scheduler_unit import lss_pkg::*; #(
	parameter int SLOTS = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	lss_cmd_if.sink   cmd,
	lss_res_if.source res
);

	// front/back handoff
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// front: decode opcode and queue the beat so the back can stall on its own
	lss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	// back: slot table, draw sequencer and result register
	// a finish clears the running slot's tickets before the draw sums them
	// the draw picks the first occupied slot whose running sum reaches
	// (random mod total) + 1, with slot 1 as fallback
	lss_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

### rtl/core/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front
// takes command beats, decodes the opcode and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module lss_front import lss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lss_cmd_if.sink cmd,
	output logic  q_valid,
	output cmd_t  q_cmd,
	input  logic  q_pop
);

	function automatic logic [1:0] classify(input logic [OPC_W-1:0] opc);
		logic [1:0] k;
		case (opc)
			OP_ADMIT:  k = KIND_ADMIT;
			OP_FINISH: k = KIND_FINISH;
			OP_TICK:   k = KIND_TICK;
			default:   k = KIND_NOP;
		endcase
		return k;
	endfunction

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign pop       = q_pop && q_valid;
	assign q_valid   = (count_q != 2'd0);
	assign q_cmd     = fifo_q[rd_ptr_q];

	always_comb begin
		in_cmd.kind    = classify(cmd.opcode);
		in_cmd.tickets = cmd.ticket_count;
		in_cmd.thread  = cmd.thread_id;
		in_cmd.rnd     = cmd.random_word;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back
// slot table and draw sequencer: serial ticket sum, bit-serial modulo, serial
// winner scan, then the result register
// ----------------------------------------------------------------------------
module lss_back import lss_pkg::*; #(
	parameter int SLOTS = 5
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  cmd_t    q_cmd,
	output logic    q_pop,
	lss_res_if.source res
);

	localparam int SLOT_W = $clog2(SLOTS + 1);
	localparam int SI_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TOT_W  = TICKET_W + ((SLOTS > 1) ? $clog2(SLOTS) : 0);
	localparam logic [SI_W-1:0] LAST = SI_W'(SLOTS - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SUM   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_APPLY = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0]          state_q;
	cmd_t                cmd_q;

	logic [1:0]          slot_status_q [SLOTS];
	logic [TICKET_W-1:0] slot_tickets_q [SLOTS];
	logic [THREAD_W-1:0] slot_thread_q [SLOTS];

	logic [SLOT_W-1:0]   run_q;
	logic                run_valid_q;
	logic [THREAD_W-1:0] run_thread_q;
	logic [SLOT_W-1:0]   before_q;
	logic [STAT_W-1:0]   stat_q;

	logic [SI_W-1:0]     idx_q;
	logic [SI_W-1:0]     win_q;
	logic [TOT_W-1:0]    acc_q;
	logic [TOT_W-1:0]    total_q;
	logic [TOT_W-1:0]    rem_q;
	logic [RAND_W-1:0]   dvd_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                res_valid_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [THREAD_W-1:0] res_thread_q;
	logic                res_switched_q;
	logic [STAT_W-1:0]   res_status_q;

	logic [SI_W-1:0]     run_idx;
	logic [SLOTS-1:0]    adm_sel;
	logic                adm_found;
	logic                adm_en;
	logic                fin_en;
	logic                promote;
	logic                demote;
	logic [TOT_W-1:0]    sum_w;
	logic [TOT_W:0]      shifted;
	logic                ge;
	logic [TOT_W:0]      draw_r;
	logic                hit;
	logic                out_free;
	logic [SLOT_W-1:0]   shown;

	assign run_idx  = SI_W'(run_q - SLOT_W'(1));
	assign adm_en   = (state_q == S_EXEC) && (cmd_q.kind == KIND_ADMIT);
	assign fin_en   = (state_q == S_EXEC) && (cmd_q.kind == KIND_FINISH) && run_valid_q;
	assign promote  = (state_q == S_APPLY);
	assign demote   = promote && run_valid_q && (win_q != run_idx);
	assign sum_w    = acc_q + TOT_W'(slot_tickets_q[idx_q]);
	assign shifted  = {rem_q, dvd_q[RAND_W-1]};
	assign ge       = (shifted >= {1'b0, total_q});
	assign draw_r   = {1'b0, rem_q} + (TOT_W + 1)'(1);
	assign hit      = (slot_status_q[idx_q] != SS_EMPTY) && (draw_r <= {1'b0, sum_w});
	assign out_free = !res_valid_q || res.ready;
	assign shown    = run_valid_q ? run_q : '0;
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	// first empty or finished slot
	always_comb begin
		logic found;
		found   = 1'b0;
		adm_sel = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && (slot_status_q[i] == SS_EMPTY ||
					slot_status_q[i] == SS_FINISHED)) begin
				adm_sel[i] = 1'b1;
				found      = 1'b1;
			end
		end
		adm_found = found;
	end

	// slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_status_q[i]  <= SS_EMPTY;
				slot_tickets_q[i] <= '0;
				slot_thread_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (adm_en && adm_sel[i]) begin
					slot_status_q[i]  <= SS_READY;
					slot_tickets_q[i] <= cmd_q.tickets;
					slot_thread_q[i]  <= cmd_q.thread;
				end else if (fin_en && run_idx == SI_W'(i)) begin
					slot_status_q[i]  <= SS_FINISHED;
					slot_tickets_q[i] <= '0;
				end else if (promote && win_q == SI_W'(i)) begin
					slot_status_q[i] <= SS_RUNNING;
				end else if (demote && run_idx == SI_W'(i)) begin
					slot_status_q[i] <= SS_READY;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_q        <= SLOT_W'(1);
			run_valid_q  <= 1'b0;
			run_thread_q <= '0;
			before_q     <= '0;
			stat_q       <= ST_OK;
			idx_q        <= '0;
			win_q        <= '0;
			acc_q        <= '0;
			total_q      <= '0;
			rem_q        <= '0;
			dvd_q        <= '0;
			cnt_q        <= '0;
			cmd_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q    <= q_cmd;
						before_q <= shown;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q  <= '0;
					acc_q  <= '0;
					case (cmd_q.kind)
						KIND_ADMIT: begin
							stat_q  <= adm_found ? ST_OK : ST_NO_SLOT;
							state_q <= S_RESP;
						end
						KIND_FINISH: begin
							stat_q <= ST_OK;
							if (run_valid_q) begin
								run_valid_q <= 1'b0;
							end
							state_q <= S_SUM;
						end
						KIND_TICK: begin
							stat_q  <= ST_OK;
							state_q <= S_SUM;
						end
						default: begin
							stat_q  <= ST_OK;
							state_q <= S_RESP;
						end
					endcase
				end
				S_SUM: begin
					acc_q <= sum_w;
					idx_q <= idx_q + SI_W'(1);
					if (idx_q == LAST) begin
						total_q <= sum_w;
						rem_q   <= '0;
						dvd_q   <= cmd_q.rnd;
						cnt_q   <= '0;
						if (sum_w == '0) begin
							stat_q  <= ST_NO_TICKETS;
							state_q <= S_RESP;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= ge ? TOT_W'(shifted - {1'b0, total_q}) : TOT_W'(shifted);
					dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(RAND_W - 1)) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					acc_q <= sum_w;
					idx_q <= idx_q + SI_W'(1);
					if (hit) begin
						win_q   <= idx_q;
						state_q <= S_APPLY;
					end else if (idx_q == LAST) begin
						win_q   <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					run_q        <= SLOT_W'(win_q) + SLOT_W'(1);
					run_valid_q  <= 1'b1;
					run_thread_q <= slot_thread_q[win_q];
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			res_slot_q     <= shown;
			res_thread_q   <= run_valid_q ? run_thread_q : '0;
			res_switched_q <= (shown != before_q);
			res_status_q   <= stat_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.chosen_slot   = res_slot_q;
	assign res.chosen_thread = res_thread_q;
	assign res.switched      = res_switched_q;
	assign res.status        = res_status_q;

endmodule

### rtl/core/lss_checker.sv
// ----------------------------------------------------------------------------
// lss_checker
// port-level checks on the result channel of the scheduler
// ----------------------------------------------------------------------------
module lss_checker import lss_pkg::*; #(
	parameter int SLOTS = 5,
	parameter int SLOT_W = $clog2(SLOTS + 1)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input logic [SLOT_W-1:0]   res_chosen_slot,
	input logic [THREAD_W-1:0] res_chosen_thread,
	input logic                res_switched,
	input logic [STAT_W-1:0]   res_status
);

	// a stalled result beat stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// no running slot means no thread shown
	a_idle_thread: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_chosen_slot == '0 |-> res_chosen_thread == '0)
		else $error("thread shown without a running slot");

	// a refused admit never moves the running slot
	a_admit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_NO_SLOT |-> !res_switched)
		else $error("switch reported on refused admit");

	// a successful switch always lands on a slot
	a_switch_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_OK && res_switched |-> res_chosen_slot != '0)
		else $error("switch to no slot with ok status");

	// shown slot within the table
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_chosen_slot <= SLOT_W'(SLOTS))
		else $error("chosen slot out of range");

endmodule

bind lottery_slot_scheduler_unit lss_checker #(.SLOTS(SLOTS)) u_lss_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_chosen_slot   (res.chosen_slot),
	.res_chosen_thread (res.chosen_thread),
	.res_switched      (res.switched),
	.res_status        (res.status)
);
